// ===== rtl/core/mips_instruction_execute_assert.svh =====
// ----------------------------------------------------------------------------
// MIPS instruction execute assertion macros
// Concurrent assertion helpers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef MIPS_INSTRUCTION_EXECUTE_ASSERT_SVH
`define MIPS_INSTRUCTION_EXECUTE_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define MIE_ASSERT_IMPLY(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
// next-cycle implication
`define MIE_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`else
`define MIE_ASSERT_IMPLY(label, clk, rst, a, b)
`define MIE_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// ===== rtl/core/mie_pkg.sv =====
// ----------------------------------------------------------------------------
// MIPS instruction execute package
// Opcodes, controller states and controller/datapath signal groups.
// ----------------------------------------------------------------------------
package mie_pkg;

   localparam int REG_COUNT = 32;
   localparam int REG_AW    = $clog2(REG_COUNT);
   localparam logic [31:0] BOOT_RESET_ADDR = 32'h0040_0000;

   // primary opcodes
   localparam logic [5:0] OP_SPECIAL = 6'd0;
   localparam logic [5:0] OP_REGIMM  = 6'd1;
   localparam logic [5:0] OP_J       = 6'd2;
   localparam logic [5:0] OP_JAL     = 6'd3;
   localparam logic [5:0] OP_BEQ     = 6'd4;
   localparam logic [5:0] OP_BNE     = 6'd5;
   localparam logic [5:0] OP_BLEZ    = 6'd6;
   localparam logic [5:0] OP_BGTZ    = 6'd7;
   localparam logic [5:0] OP_ADDI    = 6'd8;
   localparam logic [5:0] OP_ADDIU   = 6'd9;
   localparam logic [5:0] OP_SLTI    = 6'd10;
   localparam logic [5:0] OP_SLTIU   = 6'd11;
   localparam logic [5:0] OP_ANDI    = 6'd12;
   localparam logic [5:0] OP_ORI     = 6'd13;
   localparam logic [5:0] OP_XORI    = 6'd14;
   localparam logic [5:0] OP_LUI     = 6'd15;
   localparam logic [5:0] OP_LB      = 6'd32;
   localparam logic [5:0] OP_LH      = 6'd33;
   localparam logic [5:0] OP_LW      = 6'd35;
   localparam logic [5:0] OP_LBU     = 6'd36;
   localparam logic [5:0] OP_LHU     = 6'd37;
   localparam logic [5:0] OP_SB      = 6'd40;
   localparam logic [5:0] OP_SH      = 6'd41;
   localparam logic [5:0] OP_SW      = 6'd43;

   // SPECIAL functions
   localparam logic [5:0] FN_SLL   = 6'd0;
   localparam logic [5:0] FN_SRL   = 6'd2;
   localparam logic [5:0] FN_SRA   = 6'd3;
   localparam logic [5:0] FN_SLLV  = 6'd4;
   localparam logic [5:0] FN_SRLV  = 6'd6;
   localparam logic [5:0] FN_SRAV  = 6'd7;
   localparam logic [5:0] FN_JR    = 6'd8;
   localparam logic [5:0] FN_JALR  = 6'd9;
   localparam logic [5:0] FN_MFHI  = 6'd16;
   localparam logic [5:0] FN_MTHI  = 6'd17;
   localparam logic [5:0] FN_MFLO  = 6'd18;
   localparam logic [5:0] FN_MTLO  = 6'd19;
   localparam logic [5:0] FN_MULT  = 6'd24;
   localparam logic [5:0] FN_MULTU = 6'd25;
   localparam logic [5:0] FN_DIV   = 6'd26;
   localparam logic [5:0] FN_DIVU  = 6'd27;
   localparam logic [5:0] FN_ADD   = 6'd32;
   localparam logic [5:0] FN_ADDU  = 6'd33;
   localparam logic [5:0] FN_SUB   = 6'd34;
   localparam logic [5:0] FN_SUBU  = 6'd35;
   localparam logic [5:0] FN_AND   = 6'd36;
   localparam logic [5:0] FN_OR    = 6'd37;
   localparam logic [5:0] FN_XOR   = 6'd38;
   localparam logic [5:0] FN_NOR   = 6'd39;
   localparam logic [5:0] FN_SLT   = 6'd42;
   localparam logic [5:0] FN_SLTU  = 6'd43;

   // REGIMM rt codes
   localparam logic [4:0] RI_BLTZ   = 5'd0;
   localparam logic [4:0] RI_BGEZ   = 5'd1;
   localparam logic [4:0] RI_BLTZAL = 5'd16;
   localparam logic [4:0] RI_BGEZAL = 5'd17;

   // load variants (low bits of the load opcode)
   localparam logic [2:0] LV_BYTE  = 3'd0;
   localparam logic [2:0] LV_HALF  = 3'd1;
   localparam logic [2:0] LV_BYTEU = 3'd4;
   localparam logic [2:0] LV_HALFU = 3'd5;

   localparam logic [4:0] LINK_REG = 5'd31;

   // access sizes
   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_HALF = 2'd1;
   localparam logic [1:0] SIZE_WORD = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MD_WAIT,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic req_ready;
      logic capture;
      logic latch;
      logic md_start;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic is_md;
      logic md_done;
      logic out_free;
   } ctrl_status_type;

   function automatic logic [31:0] sext16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

endpackage

// ===== rtl/core/mie_req_if.sv =====
// ----------------------------------------------------------------------------
// MIPS instruction execute request channel
// Valid/ready channel carrying an instruction word or load response.
// ----------------------------------------------------------------------------
interface mie_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [31:0] word;

   modport source (output valid, output kind, output word, input ready);
   modport sink   (input valid, input kind, input word, output ready);
endinterface

// ===== rtl/core/mie_rsp_if.sv =====
// ----------------------------------------------------------------------------
// MIPS instruction execute response channel
// Valid/ready channel carrying the result of one request.
// ----------------------------------------------------------------------------
interface mie_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] fetch_address;
   logic [31:0] mem_address;
   logic [31:0] store_data;
   logic [1:0]  access_size;
   logic        read_request;
   logic        write_request;
   logic        unknown_op;

   modport source (output valid, output fetch_address, output mem_address,
                   output store_data, output access_size, output read_request,
                   output write_request, output unknown_op, input ready);
   modport sink   (input valid, input fetch_address, input mem_address,
                   input store_data, input access_size, input read_request,
                   input write_request, input unknown_op, output ready);
endinterface

// ===== rtl/core/mie_regfile.sv =====
// ----------------------------------------------------------------------------
// MIPS general register file
// Two registered read ports, one write port; per-entry valid bits make
// unwritten entries (and r0) read as zero after reset.
// ----------------------------------------------------------------------------
module mie_regfile import mie_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [REG_AW-1:0] rd_addr_a,
   input  logic [REG_AW-1:0] rd_addr_b,
   output logic [31:0]       rd_data_a,
   output logic [31:0]       rd_data_b,
   input  logic              wr_en,
   input  logic [REG_AW-1:0] wr_addr,
   input  logic [31:0]       wr_data
);

   logic [31:0]          mem [REG_COUNT];
   logic [REG_COUNT-1:0] valid_ff;
   logic [31:0]          data_a_ff, data_b_ff;
   logic                 va_ff, vb_ff;
   logic                 wr_ok;

   assign wr_ok = wr_en && (wr_addr != '0);

   // storage write and registered reads
   always_ff @(posedge clock) begin
      if (wr_ok) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         data_a_ff <= mem[rd_addr_a];
         data_b_ff <= mem[rd_addr_b];
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         va_ff    <= 1'b0;
         vb_ff    <= 1'b0;
      end else begin
         if (wr_ok) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            va_ff <= valid_ff[rd_addr_a];
            vb_ff <= valid_ff[rd_addr_b];
         end
      end
   end

   assign rd_data_a = va_ff ? data_a_ff : '0;
   assign rd_data_b = vb_ff ? data_b_ff : '0;

endmodule

// ===== rtl/core/mie_muldiv.sv =====
// ----------------------------------------------------------------------------
// MIPS multiply/divide unit
// Shift-add multiply and restoring divide on magnitudes, one bit per cycle,
// with sign fix-up on the result.
// ----------------------------------------------------------------------------
module mie_muldiv import mie_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        is_div,
   input  logic        is_signed,
   input  logic [31:0] op_a,
   input  logic [31:0] op_b,
   output logic        done,
   output logic [31:0] res_hi,
   output logic [31:0] res_lo
);

   logic        busy_ff, done_ff, div_ff, negq_ff, negr_ff;
   logic [4:0]  cnt_ff;
   logic [31:0] hi_ff, lo_ff, b_ff;
   logic [31:0] mag_a, mag_b;
   logic [32:0] add_sum;
   logic [32:0] shifted;
   logic [33:0] diff;
   logic [63:0] prod_neg;

   assign mag_a = (is_signed && op_a[31]) ? (32'd0 - op_a) : op_a;
   assign mag_b = (is_signed && op_b[31]) ? (32'd0 - op_b) : op_b;

   // one step of each algorithm
   assign add_sum = {1'b0, hi_ff} + {1'b0, (lo_ff[0] ? b_ff : 32'd0)};
   assign shifted = {hi_ff, lo_ff[31]};
   assign diff    = {1'b0, shifted} - {2'b00, b_ff};

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         hi_ff   <= '0;
         lo_ff   <= mag_a;
         b_ff    <= mag_b;
         div_ff  <= is_div;
         negq_ff <= is_signed && (op_a[31] ^ op_b[31]);
         negr_ff <= is_signed && op_a[31];
      end else if (busy_ff) begin
         if (div_ff) begin
            if (!diff[33]) begin
               hi_ff <= diff[31:0];
               lo_ff <= {lo_ff[30:0], 1'b1};
            end else begin
               hi_ff <= shifted[31:0];
               lo_ff <= {lo_ff[30:0], 1'b0};
            end
         end else begin
            hi_ff <= add_sum[32:1];
            lo_ff <= {add_sum[0], lo_ff[31:1]};
         end
      end
   end

   // sign fix-up
   assign prod_neg = 64'd0 - {hi_ff, lo_ff};

   always_comb begin
      if (div_ff) begin
         res_lo = negq_ff ? (32'd0 - lo_ff) : lo_ff;
         res_hi = negr_ff ? (32'd0 - hi_ff) : hi_ff;
      end else if (negq_ff) begin
         res_lo = prod_neg[31:0];
         res_hi = prod_neg[63:32];
      end else begin
         res_lo = lo_ff;
         res_hi = hi_ff;
      end
   end

   assign done = done_ff;

endmodule

// ===== rtl/core/mie_ctrl.sv =====
// ----------------------------------------------------------------------------
// MIPS instruction execute controller
// Sequences accept, execute, multiply/divide wait and commit.
// ----------------------------------------------------------------------------
module mie_ctrl import mie_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (status.req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = status.is_md ? ST_MD_WAIT : ST_COMMIT;
         end
         ST_MD_WAIT: begin
            if (status.md_done) state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.req_ready = 1'b1;
            cmd.capture   = status.req_valid;
         end
         ST_EXEC: begin
            cmd.latch    = 1'b1;
            cmd.md_start = status.is_md;
         end
         ST_MD_WAIT: begin
         end
         ST_COMMIT: begin
            cmd.commit = status.out_free;
         end
         default: cmd = '0;
      endcase
   end

endmodule

// ===== rtl/core/mie_datapath.sv =====
// ----------------------------------------------------------------------------
// MIPS instruction execute datapath
// Instruction decode and execute, architectural state, and response register.
// ----------------------------------------------------------------------------
module mie_datapath import mie_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_we,
   input  logic [31:0]     csr_wdata,
   input  ctrl_cmd_type    cmd,
   output ctrl_status_type status,
   mie_req_if.sink         req,
   mie_rsp_if.source       rsp
);

   // architectural and staging registers
   logic [31:0] boot_ff, boot_in;
   logic [31:0] pc_ff, pc_in;
   logic [31:0] hi_ff, lo_ff;
   logic        ld_wait_ff;
   logic [4:0]  ld_target_ff;
   logic [2:0]  ld_variant_ff;
   logic [31:0] ir_ff;
   logic        kind_ff;

   // execute results, latched
   logic        wb_en_ff, hi_we_ff, lo_we_ff, md_use_ff;
   logic [4:0]  wb_addr_ff;
   logic [31:0] wb_data_ff, hi_val_ff, lo_val_ff, next_ff;
   logic        nld_wait_ff;
   logic [4:0]  nld_target_ff;
   logic [2:0]  nld_variant_ff;
   logic [31:0] o_maddr_ff, o_sdata_ff;
   logic [1:0]  o_size_ff;
   logic        o_rd_ff, o_wr_ff, o_unk_ff;

   // execute results, combinational
   logic        wb_en, hi_we, lo_we, md_use;
   logic [4:0]  wb_addr;
   logic [31:0] wb_data, hi_val, lo_val, next_pc;
   logic        nld_wait;
   logic [4:0]  nld_target;
   logic [2:0]  nld_variant;
   logic [31:0] o_maddr, o_sdata;
   logic [1:0]  o_size;
   logic        o_rd, o_wr, o_unk;

   // response register
   logic        rsp_valid_ff;
   logic [31:0] r_fetch_ff, r_maddr_ff, r_sdata_ff;
   logic [1:0]  r_size_ff;
   logic        r_rd_ff, r_wr_ff, r_unk_ff;

   logic [31:0] vs, vt, md_hi, md_lo, imm_s, addr, pc4, br_target;
   logic [5:0]  op, fn;
   logic [4:0]  rt, rd, sa;
   logic [15:0] imm;
   logic        md_done;

   assign op  = ir_ff[31:26];
   assign rt  = ir_ff[20:16];
   assign rd  = ir_ff[15:11];
   assign sa  = ir_ff[10:6];
   assign fn  = ir_ff[5:0];
   assign imm = ir_ff[15:0];
   assign imm_s     = sext16(imm);
   assign addr      = vs + imm_s;
   assign pc4       = pc_ff + 32'd4;
   assign br_target = pc4 + {imm_s[29:0], 2'b00};

   mie_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (cmd.capture),
      .rd_addr_a (req.word[25:21]),
      .rd_addr_b (req.word[20:16]),
      .rd_data_a (vs),
      .rd_data_b (vt),
      .wr_en     (cmd.commit && wb_en_ff),
      .wr_addr   (wb_addr_ff),
      .wr_data   (wb_data_ff)
   );

   mie_muldiv u_muldiv (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.md_start),
      .is_div    (fn[1]),
      .is_signed (!fn[0]),
      .op_a      (vs),
      .op_b      (vt),
      .done      (md_done),
      .res_hi    (md_hi),
      .res_lo    (md_lo)
   );

   // capture request
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ir_ff   <= req.word;
         kind_ff <= req.kind;
      end
   end

   // decode and execute
   always_comb begin
      wb_en = 1'b0; wb_addr = rd; wb_data = '0;
      hi_we = 1'b0; lo_we = 1'b0; hi_val = vs; lo_val = vs; md_use = 1'b0;
      next_pc = pc4;
      nld_wait = 1'b0; nld_target = ld_target_ff; nld_variant = ld_variant_ff;
      o_maddr = '0; o_sdata = '0; o_size = SIZE_BYTE;
      o_rd = 1'b0; o_wr = 1'b0; o_unk = 1'b0;
      if (kind_ff) begin
         // load response
         next_pc = pc_ff;
         wb_addr = ld_target_ff;
         case (ld_variant_ff)
            LV_BYTE:  wb_data = {{24{ir_ff[7]}}, ir_ff[7:0]};
            LV_HALF:  wb_data = sext16(ir_ff[15:0]);
            LV_BYTEU: wb_data = {24'd0, ir_ff[7:0]};
            LV_HALFU: wb_data = {16'd0, ir_ff[15:0]};
            default:  wb_data = ir_ff;
         endcase
         wb_en = ld_wait_ff;
         o_unk = !ld_wait_ff;
      end else begin
         case (op)
            OP_SPECIAL: begin
               case (fn)
                  FN_SLL:  begin wb_en = 1'b1; wb_data = vt << sa; end
                  FN_SRL:  begin wb_en = 1'b1; wb_data = vt >> sa; end
                  FN_SRA:  begin wb_en = 1'b1; wb_data = $signed(vt) >>> sa; end
                  FN_SLLV: begin wb_en = 1'b1; wb_data = vt << vs[4:0]; end
                  FN_SRLV: begin wb_en = 1'b1; wb_data = vt >> vs[4:0]; end
                  FN_SRAV: begin wb_en = 1'b1; wb_data = $signed(vt) >>> vs[4:0]; end
                  FN_JR:   next_pc = vs;
                  FN_JALR: begin wb_en = 1'b1; wb_data = pc_ff + 32'd8; next_pc = vs; end
                  FN_MFHI: begin wb_en = 1'b1; wb_data = hi_ff; end
                  FN_MTHI: hi_we = 1'b1;
                  FN_MFLO: begin wb_en = 1'b1; wb_data = lo_ff; end
                  FN_MTLO: lo_we = 1'b1;
                  FN_MULT, FN_MULTU: md_use = 1'b1;
                  FN_DIV, FN_DIVU:   md_use = (vt != '0);
                  FN_ADD, FN_ADDU: begin wb_en = 1'b1; wb_data = vs + vt; end
                  FN_SUB, FN_SUBU: begin wb_en = 1'b1; wb_data = vs - vt; end
                  FN_AND:  begin wb_en = 1'b1; wb_data = vs & vt; end
                  FN_OR:   begin wb_en = 1'b1; wb_data = vs | vt; end
                  FN_XOR:  begin wb_en = 1'b1; wb_data = vs ^ vt; end
                  FN_NOR:  begin wb_en = 1'b1; wb_data = ~(vs | vt); end
                  FN_SLT:  begin
                     wb_en = 1'b1; wb_data = {31'd0, $signed(vs) < $signed(vt)};
                  end
                  FN_SLTU: begin wb_en = 1'b1; wb_data = {31'd0, vs < vt}; end
                  default: o_unk = 1'b1;
               endcase
            end
            OP_REGIMM: begin
               wb_addr = LINK_REG;
               wb_data = pc_ff + 32'd8;
               if (rt == RI_BLTZ || rt == RI_BLTZAL) begin
                  wb_en = rt[4];
                  if (vs[31]) next_pc = br_target;
               end else if (rt == RI_BGEZ || rt == RI_BGEZAL) begin
                  wb_en = rt[4];
                  if (!vs[31]) next_pc = br_target;
               end else begin
                  o_unk = 1'b1;
               end
            end
            OP_J, OP_JAL: begin
               wb_addr = LINK_REG;
               wb_data = pc_ff + 32'd8;
               wb_en   = (op == OP_JAL);
               next_pc = {pc4[31:28], ir_ff[25:0], 2'b00};
            end
            OP_BEQ:  if (vs == vt) next_pc = br_target;
            OP_BNE:  if (vs != vt) next_pc = br_target;
            OP_BLEZ: if (vs[31] || vs == '0) next_pc = br_target;
            OP_BGTZ: if (!vs[31] && vs != '0) next_pc = br_target;
            OP_ADDI, OP_ADDIU: begin wb_addr = rt; wb_en = 1'b1; wb_data = addr; end
            OP_SLTI: begin
               wb_addr = rt; wb_en = 1'b1;
               wb_data = {31'd0, $signed(vs) < $signed(imm_s)};
            end
            OP_SLTIU: begin
               wb_addr = rt; wb_en = 1'b1; wb_data = {31'd0, vs < imm_s};
            end
            OP_ANDI: begin wb_addr = rt; wb_en = 1'b1; wb_data = vs & {16'd0, imm}; end
            OP_ORI:  begin wb_addr = rt; wb_en = 1'b1; wb_data = vs | {16'd0, imm}; end
            OP_XORI: begin wb_addr = rt; wb_en = 1'b1; wb_data = vs ^ {16'd0, imm}; end
            OP_LUI:  begin wb_addr = rt; wb_en = 1'b1; wb_data = {imm, 16'd0}; end
            OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU: begin
               nld_wait    = 1'b1;
               nld_target  = rt;
               nld_variant = op[2:0];
               o_maddr = addr;
               o_size  = (op == OP_LW) ? SIZE_WORD : (op[0] ? SIZE_HALF : SIZE_BYTE);
               o_rd    = 1'b1;
            end
            OP_SB: begin
               o_maddr = addr; o_sdata = {24'd0, vt[7:0]}; o_size = SIZE_BYTE; o_wr = 1'b1;
            end
            OP_SH: begin
               o_maddr = addr; o_sdata = {16'd0, vt[15:0]}; o_size = SIZE_HALF; o_wr = 1'b1;
            end
            OP_SW: begin
               o_maddr = addr; o_sdata = vt; o_size = SIZE_WORD; o_wr = 1'b1;
            end
            default: o_unk = 1'b1;
         endcase
      end
   end

   // latch execute results
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         wb_en_ff <= wb_en;       wb_addr_ff <= wb_addr;   wb_data_ff <= wb_data;
         hi_we_ff <= hi_we;       lo_we_ff   <= lo_we;     md_use_ff  <= md_use;
         hi_val_ff <= hi_val;     lo_val_ff  <= lo_val;    next_ff    <= next_pc;
         nld_wait_ff <= nld_wait; nld_target_ff <= nld_target;
         nld_variant_ff <= nld_variant;
         o_maddr_ff <= o_maddr;   o_sdata_ff <= o_sdata;   o_size_ff  <= o_size;
         o_rd_ff  <= o_rd;        o_wr_ff    <= o_wr;      o_unk_ff   <= o_unk;
      end
   end

   // boot address register; reset sets it and the PC to BOOT_RESET_ADDR
   assign boot_in = reset ? BOOT_RESET_ADDR : (csr_we ? csr_wdata : boot_ff);
   assign pc_in   = reset ? boot_in : (cmd.commit ? next_ff : pc_ff);

   // architectural state
   always_ff @(posedge clock) begin
      boot_ff <= boot_in;
      pc_ff   <= pc_in;
      if (reset) begin
         hi_ff         <= '0;
         lo_ff         <= '0;
         ld_wait_ff    <= 1'b0;
         ld_target_ff  <= '0;
         ld_variant_ff <= '0;
      end else if (cmd.commit) begin
         if (md_use_ff) begin
            hi_ff <= md_hi;
            lo_ff <= md_lo;
         end else begin
            if (hi_we_ff) hi_ff <= hi_val_ff;
            if (lo_we_ff) lo_ff <= lo_val_ff;
         end
         ld_wait_ff    <= nld_wait_ff;
         ld_target_ff  <= nld_target_ff;
         ld_variant_ff <= nld_variant_ff;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         r_fetch_ff <= next_ff;    r_maddr_ff <= o_maddr_ff; r_sdata_ff <= o_sdata_ff;
         r_size_ff  <= o_size_ff;  r_rd_ff    <= o_rd_ff;    r_wr_ff    <= o_wr_ff;
         r_unk_ff   <= o_unk_ff;
      end
   end

   assign req.ready          = cmd.req_ready;
   assign rsp.valid          = rsp_valid_ff;
   assign rsp.fetch_address  = r_fetch_ff;
   assign rsp.mem_address    = r_maddr_ff;
   assign rsp.store_data     = r_sdata_ff;
   assign rsp.access_size    = r_size_ff;
   assign rsp.read_request   = r_rd_ff;
   assign rsp.write_request  = r_wr_ff;
   assign rsp.unknown_op     = r_unk_ff;

   assign status.req_valid = req.valid;
   assign status.is_md     = !kind_ff && (op == OP_SPECIAL) && md_use;
   assign status.md_done   = md_done;
   assign status.out_free  = !rsp_valid_ff || rsp.ready;

endmodule

// ===== rtl/core/mips_instruction_execute.sv =====
// ----------------------------------------------------------------------------
// MIPS32 integer instruction execute core
// Multicycle core executing one instruction or load response per request.
// ----------------------------------------------------------------------------
// Each request passes through accept and register read, execute, and
// commit; multiply and divide also wait for the bit-serial unit, and
// commit waits as long as the previous result is still held unaccepted on
// the response channel. One request is in flight at a time; the result
// register lets the next request be accepted while a result still waits on
// the response channel. A load returns its address with read_request set
// and completes only if the next request is a response. csr_we and csr_wdata
// write the boot register; reset sets it and the PC to BOOT_RESET_ADDR.
`include "mips_instruction_execute_assert.svh"

module mips_instruction_execute import mie_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,
   mie_req_if.sink     req_chan,
   mie_rsp_if.source   rsp_chan
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   mie_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   mie_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .req       (req_chan),
      .rsp       (rsp_chan)
   );

   // checks
   `MIE_ASSERT_IMPLY(a_commit_free, clock, reset, cmd.commit, status.out_free)
   `MIE_ASSERT_IMPLY(a_start_md, clock, reset, cmd.md_start, status.is_md && cmd.latch)
   `MIE_ASSERT_NEXT(a_start_busy, clock, reset, cmd.md_start, !status.md_done)
   `MIE_ASSERT_NEXT(a_accept_busy, clock, reset, req_chan.valid && req_chan.ready, !req_chan.ready)

endmodule

// ===== dv/tb_mips_instruction_execute.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MIPS instruction execute testbench
// Sends instruction words and load responses through the request channel,
// predicts every result with an in-bench copy of the core's architectural
// state, and checks each response field by field in order. A short directed
// table covers extremes and corner cases, then a random instruction stream
// with load responses, bursty requests and response-side stalls follows.
// ----------------------------------------------------------------------------
module tb_mips_instruction_execute;
   import mie_pkg::*;

   localparam int RANDOM_ITEMS = 1100;
   localparam int IDLE_LIMIT   = 3000;
   localparam int SETTLE       = 60;

   typedef struct packed {
      logic [31:0] fetch_address;
      logic [31:0] mem_address;
      logic [31:0] store_data;
      logic [1:0]  access_size;
      logic        read_request;
      logic        write_request;
      logic        unknown_op;
   } exec_result_type;

   typedef struct packed {
      logic            pinned;
      exec_result_type want;
   } pinned_result_type;

   typedef struct packed {
      logic              kind;
      logic [31:0]       word;
      pinned_result_type pin;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we;
   logic [31:0] csr_wdata;

   mie_req_if req_bus ();
   mie_rsp_if rsp_bus ();

   mips_instruction_execute dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus)
   );

   always #5 clock = ~clock;

   // architectural state of the predictor
   logic [31:0] gpr [32];
   logic [31:0] pc_q, hi_q, lo_q, boot_q;
   logic        load_pend;
   logic [4:0]  load_dst;
   logic [2:0]  load_kind;

   exec_result_type   expected_results [$];
   pinned_result_type pinned_q [$];
   int errors, n_req, n_rsp, n_loads, n_stores, n_muldiv, idle_cycles, burst_left;

   function automatic void set_gpr(input logic [4:0] idx, input logic [31:0] v);
      if (idx != 5'd0) gpr[idx] = v;
   endfunction

   // next state and result for one request
   function automatic exec_result_type execute_item(input logic kind, input logic [31:0] w);
      exec_result_type res;
      logic [5:0]  op, fn;
      logic [4:0]  rs, rt, rd, sa;
      logic [31:0] imm, se, vs, vt, nxt, v, ua, ub, q, r;
      logic [63:0] prod;
      logic        take;
      res = '0;
      if (kind) begin
         if (load_pend) begin
            case (load_kind)
               LV_BYTE:  v = {{24{w[7]}}, w[7:0]};
               LV_HALF:  v = {{16{w[15]}}, w[15:0]};
               LV_BYTEU: v = {24'd0, w[7:0]};
               LV_HALFU: v = {16'd0, w[15:0]};
               default:  v = w;
            endcase
            set_gpr(load_dst, v);
            load_pend = 1'b0;
         end else begin
            res.unknown_op = 1'b1;
         end
         res.fetch_address = pc_q;
         return res;
      end
      load_pend = 1'b0;
      op  = w[31:26];
      rs  = w[25:21];
      rt  = w[20:16];
      rd  = w[15:11];
      sa  = w[10:6];
      fn  = w[5:0];
      imm = {16'd0, w[15:0]};
      se  = {{16{w[15]}}, w[15:0]};
      vs  = gpr[rs];
      vt  = gpr[rt];
      nxt = pc_q + 32'd4;
      case (op)
         OP_SPECIAL: begin
            case (fn)
               FN_SLL:  set_gpr(rd, vt << sa);
               FN_SRL:  set_gpr(rd, vt >> sa);
               FN_SRA:  set_gpr(rd, $signed(vt) >>> sa);
               FN_SLLV: set_gpr(rd, vt << vs[4:0]);
               FN_SRLV: set_gpr(rd, vt >> vs[4:0]);
               FN_SRAV: set_gpr(rd, $signed(vt) >>> vs[4:0]);
               FN_JR:   nxt = vs;
               FN_JALR: begin
                  set_gpr(rd, pc_q + 32'd8);
                  nxt = vs;
               end
               FN_MFHI: set_gpr(rd, hi_q);
               FN_MTHI: hi_q = vs;
               FN_MFLO: set_gpr(rd, lo_q);
               FN_MTLO: lo_q = vs;
               FN_MULT: begin
                  prod = {{32{vs[31]}}, vs} * {{32{vt[31]}}, vt};
                  {hi_q, lo_q} = prod;
               end
               FN_MULTU: begin
                  prod = {32'd0, vs} * {32'd0, vt};
                  {hi_q, lo_q} = prod;
               end
               FN_DIV: begin
                  // divide by zero keeps HI/LO
                  if (vt != 32'd0) begin
                     ua = vs[31] ? -vs : vs;
                     ub = vt[31] ? -vt : vt;
                     q = ua / ub;
                     r = ua % ub;
                     if (vs[31] ^ vt[31]) q = -q;
                     if (vs[31]) r = -r;
                     lo_q = q;
                     hi_q = r;
                  end
               end
               FN_DIVU: begin
                  if (vt != 32'd0) begin
                     lo_q = vs / vt;
                     hi_q = vs % vt;
                  end
               end
               FN_ADD, FN_ADDU: set_gpr(rd, vs + vt);
               FN_SUB, FN_SUBU: set_gpr(rd, vs - vt);
               FN_AND:  set_gpr(rd, vs & vt);
               FN_OR:   set_gpr(rd, vs | vt);
               FN_XOR:  set_gpr(rd, vs ^ vt);
               FN_NOR:  set_gpr(rd, ~(vs | vt));
               FN_SLT:  set_gpr(rd, {31'd0, $signed(vs) < $signed(vt)});
               FN_SLTU: set_gpr(rd, {31'd0, vs < vt});
               default: res.unknown_op = 1'b1;
            endcase
         end
         OP_REGIMM: begin
            if (rt == RI_BLTZ || rt == RI_BLTZAL || rt == RI_BGEZ || rt == RI_BGEZAL) begin
               take = (rt == RI_BLTZ || rt == RI_BLTZAL) ? vs[31] : !vs[31];
               if (rt[4]) set_gpr(LINK_REG, pc_q + 32'd8);
               if (take) nxt = pc_q + 32'd4 + (se << 2);
            end else begin
               res.unknown_op = 1'b1;
            end
         end
         OP_J, OP_JAL: begin
            if (op == OP_JAL) set_gpr(LINK_REG, pc_q + 32'd8);
            nxt = {nxt[31:28], w[25:0], 2'b00};
         end
         OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ: begin
            case (op)
               OP_BEQ:  take = (vs == vt);
               OP_BNE:  take = (vs != vt);
               OP_BLEZ: take = vs[31] || vs == 32'd0;
               default: take = !vs[31] && vs != 32'd0;
            endcase
            if (take) nxt = pc_q + 32'd4 + (se << 2);
         end
         OP_ADDI, OP_ADDIU: set_gpr(rt, vs + se);
         OP_SLTI:  set_gpr(rt, {31'd0, $signed(vs) < $signed(se)});
         OP_SLTIU: set_gpr(rt, {31'd0, vs < se});
         OP_ANDI:  set_gpr(rt, vs & imm);
         OP_ORI:   set_gpr(rt, vs | imm);
         OP_XORI:  set_gpr(rt, vs ^ imm);
         OP_LUI:   set_gpr(rt, {w[15:0], 16'd0});
         OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU: begin
            load_pend = 1'b1;
            load_dst  = rt;
            load_kind = op[2:0];
            res.mem_address  = vs + se;
            res.access_size  = (op == OP_LW) ? SIZE_WORD : (op[0] ? SIZE_HALF : SIZE_BYTE);
            res.read_request = 1'b1;
         end
         OP_SB, OP_SH, OP_SW: begin
            res.mem_address   = vs + se;
            res.write_request = 1'b1;
            case (op)
               OP_SB: begin
                  res.store_data  = {24'd0, vt[7:0]};
                  res.access_size = SIZE_BYTE;
               end
               OP_SH: begin
                  res.store_data  = {16'd0, vt[15:0]};
                  res.access_size = SIZE_HALF;
               end
               default: begin
                  res.store_data  = vt;
                  res.access_size = SIZE_WORD;
               end
            endcase
         end
         default: res.unknown_op = 1'b1;
      endcase
      pc_q = nxt;
      res.fetch_address = nxt;
      return res;
   endfunction

   function automatic logic [31:0] r_type(input logic [5:0] fn, input logic [4:0] rs,
                                          input logic [4:0] rt, input logic [4:0] rd,
                                          input logic [4:0] sa);
      return {OP_SPECIAL, rs, rt, rd, sa, fn};
   endfunction

   function automatic logic [31:0] i_type(input logic [5:0] op, input logic [4:0] rs,
                                          input logic [4:0] rt, input logic [15:0] imm);
      return {op, rs, rt, imm};
   endfunction

   function automatic logic [4:0] pick_reg();
      return ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                         : 5'($urandom_range(0, 7));
   endfunction

   // random well-formed instruction, mostly from the implemented set
   function automatic logic [31:0] gen_instruction();
      logic [5:0]  fns [26] = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV,
                                FN_JR, FN_JALR, FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO,
                                FN_MULT, FN_MULTU, FN_DIV, FN_DIVU, FN_ADD, FN_ADDU,
                                FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_XOR, FN_NOR,
                                FN_SLT, FN_SLTU};
      logic [4:0]  ris [4] = '{RI_BLTZ, RI_BGEZ, RI_BLTZAL, RI_BGEZAL};
      logic [5:0]  loads [5] = '{OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU};
      logic [5:0]  stores [3] = '{OP_SB, OP_SH, OP_SW};
      logic [15:0] imm;
      imm = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 64));
      case ($urandom_range(0, 19))
         0, 1, 2, 3, 4, 5:
            return r_type(fns[$urandom_range(0, 25)], pick_reg(), pick_reg(), pick_reg(),
                          5'($urandom));
         6: return i_type(OP_REGIMM, pick_reg(), ris[$urandom_range(0, 3)], imm);
         7, 8: return i_type(6'($urandom_range(OP_BEQ, OP_BGTZ)), pick_reg(), pick_reg(), imm);
         9: return {6'($urandom_range(OP_J, OP_JAL)), 26'($urandom)};
         10, 11, 12, 13:
            return i_type(6'($urandom_range(OP_ADDI, OP_LUI)), pick_reg(), pick_reg(), imm);
         14, 15, 16: return i_type(loads[$urandom_range(0, 4)], pick_reg(), pick_reg(), imm);
         17, 18: return i_type(stores[$urandom_range(0, 2)], pick_reg(), pick_reg(), imm);
         default: return $urandom;
      endcase
   endfunction

   // send one request; the sender runs in bursts separated by random gaps
   task automatic send_item(input logic kind, input logic [31:0] w,
                            input pinned_result_type pin);
      int gap;
      pinned_q.push_back(pin);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            @(negedge clock);
            req_bus.valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_bus.valid = 1'b1;
      req_bus.kind  = kind;
      req_bus.word  = w;
      if (!kind && w[31:26] inside {OP_SB, OP_SH, OP_SW}) n_stores++;
      if (!kind && w[31:26] == OP_SPECIAL && w[5:0] inside {FN_MULT, FN_MULTU, FN_DIV, FN_DIVU})
         n_muldiv++;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // hold off until every outstanding result has come back
   task automatic drain();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (expected_results.size() != 0 || pinned_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_boot(input logic [31:0] v);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_wdata = v;
      @(negedge clock);
      csr_we    = 1'b0;
      boot_q    = v;
   endtask

   task automatic random_phase(input int count);
      logic [31:0] w;
      int sent;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 39) == 0) begin
            // stray response; it completes a load only if one was left pending
            send_item(1'b1, $urandom, '0);
            sent++;
         end else begin
            w = gen_instruction();
            send_item(1'b0, w, '0);
            sent++;
            if (w[31:26] inside {OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU}) begin
               n_loads++;
               if ($urandom_range(0, 9) != 0) begin
                  send_item(1'b1, $urandom, '0);
                  sent++;
               end
            end
         end
      end
   endtask

   // response-side stalls: free running, random, or long stall runs
   int stall_mode, stall_run, mode_left;
   always @(negedge clock) begin
      if (mode_left == 0) begin
         mode_left  = $urandom_range(50, 300);
         stall_mode = $urandom_range(0, 2);
      end
      mode_left--;
      case (stall_mode)
         0: rsp_bus.ready <= 1'b1;
         1: rsp_bus.ready <= ($urandom_range(0, 1) == 1);
         default: begin
            if (stall_run == 0) stall_run = $urandom_range(1, 30);
            stall_run--;
            rsp_bus.ready <= (stall_run < 3);
         end
      endcase
   end

   // prediction on request acceptance, checking on response acceptance
   always @(posedge clock) begin : monitor_b
      pinned_result_type pin;
      exec_result_type   pred, got, exp;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            pin  = pinned_q.pop_front();
            pred = execute_item(req_bus.kind, req_bus.word);
            expected_results.push_back(pin.pinned ? pin.want : pred);
            n_req++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.fetch_address, rsp_bus.mem_address, rsp_bus.store_data,
                    rsp_bus.access_size, rsp_bus.read_request, rsp_bus.write_request,
                    rsp_bus.unknown_op};
            n_rsp++;
            if (expected_results.size() == 0) begin
               $display("%0t: result with nothing expected: %h", $realtime, got);
               errors++;
            end else begin
               exp = expected_results.pop_front();
               if (exp != got) begin
                  errors++;
                  if (exp.fetch_address != got.fetch_address)
                     $display("%0t: fetch_address exp %h got %h", $realtime,
                              exp.fetch_address, got.fetch_address);
                  if (exp.mem_address != got.mem_address)
                     $display("%0t: mem_address exp %h got %h", $realtime,
                              exp.mem_address, got.mem_address);
                  if (exp.store_data != got.store_data)
                     $display("%0t: store_data exp %h got %h", $realtime,
                              exp.store_data, got.store_data);
                  if (exp.access_size != got.access_size)
                     $display("%0t: access_size exp %0d got %0d", $realtime,
                              exp.access_size, got.access_size);
                  if (exp.read_request != got.read_request)
                     $display("%0t: read_request exp %b got %b", $realtime,
                              exp.read_request, got.read_request);
                  if (exp.write_request != got.write_request)
                     $display("%0t: write_request exp %b got %b", $realtime,
                              exp.write_request, got.write_request);
                  if (exp.unknown_op != got.unknown_op)
                     $display("%0t: unknown_op exp %b got %b", $realtime,
                              exp.unknown_op, got.unknown_op);
               end
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $realtime, IDLE_LIMIT);
         $display("TEST FAILED");
         $finish;
      end
   end

   stim_row_type dir_rows [$];

   function automatic stim_row_type row(input logic kind, input logic [31:0] w);
      return '{kind, w, '0};
   endfunction

   initial begin
      stim_row_type r;
      req_bus.valid = 1'b0;
      req_bus.kind  = 1'b0;
      req_bus.word  = '0;
      rsp_bus.ready = 1'b0;
      csr_we        = 1'b0;
      csr_wdata     = '0;
      errors = 0; n_req = 0; n_rsp = 0; n_loads = 0; n_stores = 0; n_muldiv = 0;
      idle_cycles = 0; burst_left = 0; mode_left = 0; stall_run = 0; stall_mode = 0;
      foreach (gpr[i]) gpr[i] = '0;
      boot_q = BOOT_RESET_ADDR;
      pc_q = BOOT_RESET_ADDR;
      hi_q = '0; lo_q = '0;
      load_pend = 1'b0; load_dst = '0; load_kind = '0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      write_boot(32'hFFFF_FFFF);

      // directed table: response with no load and unknown opcode have fixed results
      r = row(1'b1, 32'hFFFF_FFFF);
      r.pin = '{1'b1, '{BOOT_RESET_ADDR, 32'd0, 32'd0, SIZE_BYTE, 1'b0, 1'b0, 1'b1}};
      dir_rows.push_back(r);
      r = row(1'b0, 32'hFFFF_FFFF);
      r.pin = '{1'b1, '{BOOT_RESET_ADDR + 32'd4, 32'd0, 32'd0, SIZE_BYTE, 1'b0, 1'b0, 1'b1}};
      dir_rows.push_back(r);
      dir_rows.push_back(row(1'b0, i_type(OP_LUI, 5'd0, 5'd1, 16'h8000)));
      dir_rows.push_back(row(1'b0, i_type(OP_ADDIU, 5'd0, 5'd3, 16'hFFFF)));
      dir_rows.push_back(row(1'b0, i_type(OP_ADDIU, 5'd0, 5'd0, 16'h0005)));   // r0 stays zero
      dir_rows.push_back(row(1'b0, r_type(FN_SLT, 5'd1, 5'd3, 5'd4, 5'd0)));
      dir_rows.push_back(row(1'b0, r_type(FN_SLTU, 5'd1, 5'd3, 5'd5, 5'd0)));
      dir_rows.push_back(row(1'b0, i_type(OP_SLTIU, 5'd1, 5'd6, 16'hFFFF)));
      dir_rows.push_back(row(1'b0, r_type(FN_DIV, 5'd1, 5'd3, 5'd0, 5'd0)));   // min / -1
      dir_rows.push_back(row(1'b0, r_type(FN_MFHI, 5'd0, 5'd0, 5'd7, 5'd0)));
      dir_rows.push_back(row(1'b0, r_type(FN_DIVU, 5'd3, 5'd0, 5'd0, 5'd0)));  // by zero
      dir_rows.push_back(row(1'b0, r_type(FN_MFLO, 5'd0, 5'd0, 5'd8, 5'd0)));
      dir_rows.push_back(row(1'b0, r_type(FN_MULT, 5'd1, 5'd1, 5'd0, 5'd0)));
      dir_rows.push_back(row(1'b0, r_type(FN_MULTU, 5'd3, 5'd3, 5'd0, 5'd0)));
      dir_rows.push_back(row(1'b0, r_type(FN_SRA, 5'd0, 5'd1, 5'd9, 5'd31)));
      dir_rows.push_back(row(1'b0, i_type(OP_SW, 5'd3, 5'd1, 16'h8000)));
      dir_rows.push_back(row(1'b0, i_type(OP_SB, 5'd1, 5'd3, 16'h7FFF)));
      dir_rows.push_back(row(1'b0, i_type(OP_LB, 5'd0, 5'd10, 16'hFFFF)));
      dir_rows.push_back(row(1'b1, 32'h0000_0080));
      dir_rows.push_back(row(1'b0, i_type(OP_LHU, 5'd3, 5'd11, 16'h0001)));
      dir_rows.push_back(row(1'b0, i_type(OP_ORI, 5'd0, 5'd12, 16'hFFFF))); // drops the load
      dir_rows.push_back(row(1'b0, i_type(OP_REGIMM, 5'd1, RI_BLTZAL, 16'h8000)));
      dir_rows.push_back(row(1'b0, {OP_JAL, 26'h3FF_FFFF}));
      dir_rows.push_back(row(1'b0, r_type(FN_JALR, 5'd3, 5'd0, 5'd13, 5'd0)));
      dir_rows.push_back(row(1'b0, i_type(OP_REGIMM, 5'd0, 5'd2, 16'h0000))); // undefined rt

      foreach (dir_rows[i]) send_item(dir_rows[i].kind, dir_rows[i].word, dir_rows[i].pin);
      drain();
      write_boot(32'h0000_0000);
      random_phase(RANDOM_ITEMS / 2);
      drain();
      write_boot($urandom);
      random_phase(RANDOM_ITEMS - RANDOM_ITEMS / 2);
      drain();

      $display("Ran %0d requests, checked %0d results", n_req, n_rsp);
      $display("Covered %0d loads, %0d stores, %0d multiply/divide ops", n_loads, n_stores,
               n_muldiv);
      if (errors == 0 && expected_results.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== mips_instruction_execute.f =====
+incdir+rtl/core
rtl/core/mie_pkg.sv
rtl/core/mie_req_if.sv
rtl/core/mie_rsp_if.sv
rtl/core/mie_regfile.sv
rtl/core/mie_muldiv.sv
rtl/core/mie_ctrl.sv
rtl/core/mie_datapath.sv
rtl/core/mips_instruction_execute.sv
dv/tb_mips_instruction_execute.sv
